// ===== hw/rtl/edf_pkg.sv =====
package edf_pkg;

  localparam int Entries   = 16;
  localparam int SlotW     = 4;
  localparam int TimeW     = 32;
  localparam int CountW    = 5;

  localparam logic [2:0] KIND_WRITE  = 3'd0;
  localparam logic [2:0] KIND_ACT    = 3'd1;
  localparam logic [2:0] KIND_DEACT  = 3'd2;
  localparam logic [2:0] KIND_ELAPSE = 3'd3;
  localparam logic [2:0] KIND_PICK   = 3'd4;
  localparam logic [2:0] KIND_SNAP   = 3'd5;
  localparam logic [2:0] KIND_REST   = 3'd6;
  localparam logic [2:0] KIND_RTIMES = 3'd7;

  localparam logic [1:0] CLS_PERIODIC  = 2'd0;
  localparam logic [1:0] CLS_BURSTY    = 2'd1;
  localparam logic [1:0] CLS_APERIODIC = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_LIST = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DONE = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/edf_event_deadline_table_top.sv =====
// Event deadline table, earliest deadline first. One request at a time: a
// request is taken, then a sequencer walks a shared index over the sixteen
// slots (or list positions) one per cycle, using one saturating due/mask
// subtract pair and one due/period comparator, then a finish state (S_DONE)
// registers the result, which the output state (S_OUT) then presents.
// in_ready is low from accept until the result is taken, so the result
// register holds until out_ready. Write entry updates its slot during the
// scan as well, which keeps the timing the same for every kind.
// guard_delay is written over cfg_valid/cfg_ready; the user must write it
// only while idle, as the block itself does not enforce this. cfg_ready is
// always high.
module edf_event_deadline_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [3:0]  slot,
  input  logic [31:0] time_value,
  input  logic [31:0] period_value,
  input  logic [1:0]  event_class,
  input  logic [31:0] mask_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [3:0]  chosen_slot,
  output logic [15:0] wait_time,
  output logic [1:0]  status
);

  localparam int N = edf_pkg::Entries;
  localparam int SW = edf_pkg::SlotW;
  localparam int TW = edf_pkg::TimeW;
  localparam int CW = edf_pkg::CountW;

  edf_pkg::state_t state;

  logic [15:0] guard_delay;

  logic [TW-1:0] next_due     [N];
  logic [TW-1:0] period_store [N];
  logic [1:0]    class_store  [N];
  logic [TW-1:0] mask_left    [N];
  logic [TW-1:0] saved_due    [N];
  logic [N-1:0]  entry_valid;
  logic [SW-1:0] active_order [N];
  logic [CW-1:0] active_count;

  // latched request
  logic [2:0]    r_kind;
  logic [SW-1:0] r_slot;
  logic [TW-1:0] r_time, r_per, r_mask;
  logic [1:0]    r_cls;

  // scan state
  logic [CW-1:0] idx;
  logic          hit;        // slot found in active list
  logic [SW-1:0] hit_pos;
  logic          b_found;
  logic [TW-1:0] b_due, b_per;
  logic [SW-1:0] b_slot;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == edf_pkg::S_IDLE);
  assign out_valid = (state == edf_pkg::S_OUT);

  always_ff @(posedge clk) begin
    if (rst) guard_delay <= '0;
    else if (cfg_valid) guard_delay <= cfg_data;
  end

  // per-cycle views of the element under the index
  logic [SW-1:0] pos;
  logic          in_list;
  logic [SW-1:0] ls;          // slot at list position
  logic [SW-1:0] es;          // slot by direct index
  logic          better;

  assign pos     = idx[SW-1:0];
  assign in_list = idx < active_count;
  assign ls      = active_order[pos];
  assign es      = pos;

  // shared comparator
  assign better = !b_found || (next_due[ls] < b_due) ||
                  ((next_due[ls] == b_due) && (period_store[ls] < b_per));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= edf_pkg::S_IDLE;
      entry_valid  <= '0;
      active_count <= '0;
      for (int i = 0; i < N; i++) begin
        next_due[i]     <= '0;
        period_store[i] <= '0;
        class_store[i]  <= '0;
        mask_left[i]    <= '0;
        saved_due[i]    <= '0;
      end
    end else begin
      unique case (state)
        edf_pkg::S_IDLE: begin
          if (in_valid) begin
            r_kind  <= kind;
            r_slot  <= slot;
            r_time  <= time_value;
            r_per   <= period_value;
            r_cls   <= event_class;
            r_mask  <= mask_value;
            idx     <= '0;
            hit     <= 1'b0;
            hit_pos <= '0;
            b_found <= 1'b0;
            b_due   <= '1;
            b_per   <= '0;
            b_slot  <= '0;
            state   <= edf_pkg::S_SCAN;
          end
        end
        edf_pkg::S_SCAN: begin
          unique case (r_kind)
            edf_pkg::KIND_WRITE: begin
              if (idx == '0) begin
                next_due[r_slot]     <= r_time;
                period_store[r_slot] <= r_per;
                class_store[r_slot]  <= r_cls;
                mask_left[r_slot]    <= r_mask;
                entry_valid[r_slot]  <= 1'b1;
              end
            end
            edf_pkg::KIND_ACT, edf_pkg::KIND_DEACT: begin
              if (in_list && !hit && ls == r_slot) begin
                hit     <= 1'b1;
                hit_pos <= pos;
              end
            end
            edf_pkg::KIND_ELAPSE: begin
              // one slot per cycle: due time, and mask timer when aperiodic
              if (entry_valid[es]) begin
                next_due[es] <= (next_due[es] > r_time) ? next_due[es] - r_time : '0;
                if (class_store[es] == edf_pkg::CLS_APERIODIC)
                  mask_left[es] <= (mask_left[es] > r_time) ?
                                   mask_left[es] - r_time : '0;
              end
            end
            edf_pkg::KIND_PICK: begin
              if (in_list && better) begin
                b_found <= 1'b1;
                b_due   <= next_due[ls];
                b_per   <= period_store[ls];
                b_slot  <= ls;
              end
            end
            edf_pkg::KIND_SNAP: begin
              if (in_list) saved_due[ls] <= next_due[ls];
            end
            edf_pkg::KIND_REST: begin
              if (in_list) next_due[ls] <= saved_due[ls];
            end
            edf_pkg::KIND_RTIMES: begin
              if (entry_valid[es] && (class_store[es] == edf_pkg::CLS_PERIODIC ||
                                      class_store[es] == edf_pkg::CLS_BURSTY))
                next_due[es] <= '0;
            end
            default: ;
          endcase
          if (idx == CW'(N - 1)) state <= edf_pkg::S_DONE;
          idx <= idx + 1'b1;
        end
        edf_pkg::S_DONE: begin
          found       <= 1'b0;
          chosen_slot <= '0;
          wait_time   <= '0;
          status      <= edf_pkg::ST_OK;
          unique case (r_kind)
            edf_pkg::KIND_ACT: begin
              if (!hit) begin
                if (active_count >= CW'(N)) status <= edf_pkg::ST_FULL;
                else begin
                  active_order[active_count[SW-1:0]] <= r_slot;
                  active_count <= active_count + 1'b1;
                end
              end
            end
            edf_pkg::KIND_DEACT: begin
              if (!hit) status <= edf_pkg::ST_NOT_LIST;
              else begin
                active_order[hit_pos] <= active_order[SW'(active_count - 1'b1)];
                active_count <= active_count - 1'b1;
              end
            end
            edf_pkg::KIND_PICK: begin
              found       <= b_found;
              chosen_slot <= b_slot;
              wait_time   <= (b_due > TW'(16'hFFFF)) ? 16'hFFFF - guard_delay :
                                                       b_due[15:0];
            end
            default: ;
          endcase
          state <= edf_pkg::S_OUT;
        end
        edf_pkg::S_OUT: begin
          if (out_ready) state <= edf_pkg::S_IDLE;
        end
        default: state <= edf_pkg::S_IDLE;
      endcase
    end
  end

endmodule
